[hw/rtl/ksm_pkg.sv]
// Shared types, constants and helper functions of the key sequence matcher.
package ksm_pkg;

    localparam int KSM_NUM_KEYS    = 4;
    localparam int KSM_MAX_KEY_LEN = 8;

    localparam int CHAR_W      = 7;
    localparam int SEQ_W       = 60;
    localparam int IDX_W       = 4;
    localparam int KEY_SEL_W   = 3;
    localparam int CFG_COUNT   = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int LEN_LSB     = 56;
    localparam int QUEUE_DEPTH = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_LEFT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_RIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_UP    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_DOWN  = 2'd3;

    // Fixed key codes: ctl(b), ctl(f), ctl(p) and ctl(n).
    localparam logic [CHAR_W-1:0] CODE_LEFT  = 7'h02;
    localparam logic [CHAR_W-1:0] CODE_RIGHT = 7'h06;
    localparam logic [CHAR_W-1:0] CODE_UP    = 7'h10;
    localparam logic [CHAR_W-1:0] CODE_DOWN  = 7'h0e;

    localparam logic CMD_CHAR    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // One configuration write as seen by the front and back parts.
    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]      data;
    } t_cfg_wr;

    // One queued job: replay cnt characters of key's sequence, then the tail if has_tail.
    typedef struct packed {
        logic [KEY_SEL_W-1:0] key;
        logic [IDX_W-1:0]     cnt;
        logic                 has_tail;
        logic [CHAR_W-1:0]    tail;
    } t_job;

    function automatic logic [CHAR_W-1:0] key_code(input int k);
        logic [CHAR_W-1:0] code;
        case (k)
            0:       code = CODE_LEFT;
            1:       code = CODE_RIGHT;
            2:       code = CODE_UP;
            3:       code = CODE_DOWN;
            default: code = '0;
        endcase
        return code;
    endfunction

    function automatic logic [CHAR_W-1:0] seq_char(input logic [SEQ_W-1:0] seq,
                                                   input logic [2:0] pos);
        return seq[pos * CHAR_W +: CHAR_W];
    endfunction

endpackage

[hw/rtl/ksm_front.sv]
// Front part: accepts items, advances the match indices and queues output jobs.
module ksm_front
    import ksm_pkg::*;
#(
    parameter int NUM_KEYS    = KSM_NUM_KEYS,
    parameter int MAX_KEY_LEN = KSM_MAX_KEY_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg_wr          i_cfg,
    input  logic [SEQ_W-1:0] i_key_seq [NUM_KEYS],
    input  logic             i_accept,
    input  logic             i_cmd,
    input  logic [CHAR_W-1:0] i_char,
    output logic             o_push,
    output t_job             o_job
);

    localparam logic [IDX_W-1:0] LEN_MAX = IDX_W'(MAX_KEY_LEN);

    logic [IDX_W-1:0] r_mi [NUM_KEYS];
    logic [IDX_W-1:0] n_mi [NUM_KEYS];

    logic [NUM_KEYS-1:0] adv;
    logic                any_adv;
    logic                any_done;
    logic [CHAR_W-1:0]   done_code;
    logic                best_vld;
    logic [KEY_SEL_W-1:0] best_key;
    logic [IDX_W-1:0]    best_val;
    logic [IDX_W-1:0]    best_cnt;

    always_comb begin
        logic [IDX_W-1:0] len;
        adv       = '0;
        any_done  = 1'b0;
        done_code = '0;
        best_vld  = 1'b0;
        best_key  = '0;
        best_val  = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            len = i_key_seq[k][LEN_LSB +: IDX_W];
            if (len > LEN_MAX) begin
                len = LEN_MAX;
            end
            adv[k] = (len != '0) && (r_mi[k] < len) &&
                     (seq_char(i_key_seq[k], r_mi[k][2:0]) == i_char);
            // The lowest key that completes decides the code.
            if (adv[k] && !any_done && ((r_mi[k] + IDX_W'(1)) >= len)) begin
                any_done  = 1'b1;
                done_code = key_code(k);
            end
            // Longest partial prefix; ties go to the lowest key.
            if (r_mi[k] != '0 && (!best_vld || best_val < r_mi[k])) begin
                best_vld = 1'b1;
                best_key = KEY_SEL_W'(k);
                best_val = r_mi[k];
            end
        end
        any_adv  = |adv;
        best_cnt = (best_val > LEN_MAX) ? LEN_MAX : best_val;
    end

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_mi[k] = r_mi[k];
        end
        o_push = 1'b0;
        o_job  = '{key: best_key, cnt: best_cnt, has_tail: 1'b0, tail: i_char};
        if (i_accept) begin
            if (i_cmd == CMD_TIMEOUT) begin
                o_push = best_vld;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    n_mi[k] = '0;
                end
            end else if (any_done) begin
                o_push         = 1'b1;
                o_job.cnt      = '0;
                o_job.has_tail = 1'b1;
                o_job.tail     = done_code;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    n_mi[k] = '0;
                end
            end else if (any_adv) begin
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (adv[k]) begin
                        n_mi[k] = r_mi[k] + IDX_W'(1);
                    end
                end
            end else begin
                o_push         = 1'b1;
                o_job.has_tail = 1'b1;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    n_mi[k] = '0;
                end
            end
        end
        // Rewriting a key sequence restarts that key's match.
        if (i_cfg.we) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (k < CFG_COUNT && CFG_ADDR_W'(k) == i_cfg.addr) begin
                    n_mi[k] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!i_rst_n) begin
                r_mi[k] <= '0;
            end else begin
                r_mi[k] <= n_mi[k];
            end
        end
    end

endmodule

[hw/rtl/ksm_queue.sv]
// Short job queue between the front and back parts.
module ksm_queue
    import ksm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

[hw/rtl/ksm_back.sv]
// Back part: expands queued jobs into result items behind an output register.
module ksm_back
    import ksm_pkg::*;
#(
    parameter int NUM_KEYS = KSM_NUM_KEYS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SEQ_W-1:0] i_key_seq [NUM_KEYS],
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tlast
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic [IDX_W-1:0]  r_pos;

    logic              load;
    logic              in_prefix;
    logic [CHAR_W-1:0] nxt_char;
    logic              nxt_last;

    assign load      = !r_valid || i_m_tready;
    assign in_prefix = r_pos < i_job.cnt;
    assign nxt_char  = in_prefix ? seq_char(i_key_seq[i_job.key[KEY_W-1:0]], r_pos[2:0])
                                 : i_job.tail;
    assign nxt_last  = in_prefix ? ((r_pos + IDX_W'(1)) == i_job.cnt) && !i_job.has_tail
                                 : 1'b1;
    assign o_pop     = load && i_job_valid && nxt_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (load) begin
            r_valid <= i_job_valid;
            if (i_job_valid) begin
                r_pos <= nxt_last ? '0 : r_pos + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_job_valid) begin
            r_char <= nxt_char;
            r_last <= nxt_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {1'b0, r_char};
    assign o_m_tlast  = r_last;

endmodule

[hw/rtl/key_sequence_matcher.sv]
// Top level of the key sequence matcher: configuration registers and the two parts.
//
// Usage: characters and timeouts arrive as requests on the slave stream
// (tdata holds the 7-bit character, tuser is the command: 0 character,
// 1 inter-character timeout). Results leave on the master stream as
// characters or key codes, with tlast on the final result caused
// by one input request. Four key sequences are written through the plain
// write port (index 0 left, 1 right, 2 up, 3 down; 7-bit characters from
// the low bits, length in bits 59:56, length zero disables the key).
// Configuration must be written only while idle; the block does not enforce it.
//
// The front classifies a request in the cycle it is accepted and queues a
// job, whose first result passes through the job queue and the output
// register. The front takes one request per cycle while its two-entry job
// queue has room; the back part sends one result per cycle while the receiver
// is ready, so a replayed prefix of n characters plus the character makes n+1 results.
// A stalled receiver fills the queue and then deasserts the slave tready.
// Reset (synchronous, active low) clears the key registers, all match
// indices, the queue and the output register.
module key_sequence_matcher
    import ksm_pkg::*;
#(
    parameter int NUM_KEYS    = KSM_NUM_KEYS,
    parameter int MAX_KEY_LEN = KSM_MAX_KEY_LEN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [SEQ_W-1:0]      i_cfg_wdata,
    // Slave stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [6:0] char_in, [7] zero
    input  logic                  s_tuser,   // [0] cmd
    // Master stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [6:0] char_out, [7] zero
    output logic                  m_tlast    // last_of_run
);

    // Key sequence registers; keys beyond the register list read as disabled.
    logic [SEQ_W-1:0] r_key_seq [CFG_COUNT];
    logic [SEQ_W-1:0] key_seq   [NUM_KEYS];

    t_cfg_wr cfg;
    logic    accept;
    logic    push;
    t_job    job;
    logic    q_full;
    logic    q_valid;
    t_job    q_head;
    logic    pop;

    assign cfg = '{we: i_cfg_we, addr: i_cfg_addr, data: i_cfg_wdata};

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CFG_COUNT; k++) begin
            if (!i_rst_n) begin
                r_key_seq[k] <= '0;
            end else if (cfg.we && cfg.addr == CFG_ADDR_W'(k)) begin
                r_key_seq[k] <= cfg.data;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_seq[k] = '0;
            if (k < CFG_COUNT) begin
                key_seq[k] = r_key_seq[k];
            end
        end
    end

    // The front is free whenever the queue can take another job.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    ksm_front #(
        .NUM_KEYS    (NUM_KEYS),
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_key_seq (key_seq),
        .i_accept  (accept),
        .i_cmd     (s_tuser),
        .i_char    (s_tdata[CHAR_W-1:0]),
        .o_push    (push),
        .o_job     (job)
    );

    ksm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    ksm_back #(
        .NUM_KEYS (NUM_KEYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_seq   (key_seq),
        .i_job_valid (q_valid),
        .i_job       (q_head),
        .o_pop       (pop),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

endmodule

[tb/tb_key_sequence_matcher.sv]
// Self-checking testbench of the key sequence matcher: stream driver, result monitor and predictor.
module tb_key_sequence_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import ksm_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 8;
    // Cycles to wait after the last result before a register write or the
    // final verdict; covers requests that leave no result but are still in flight.
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned RUN_LIMIT    = 400000;

    // A few terminal characters used by the directed part.
    localparam logic [CHAR_W-1:0] CH_ESC   = 7'h1b;
    localparam logic [CHAR_W-1:0] CH_LBRKT = 7'h5b;
    localparam logic [CHAR_W-1:0] CH_O     = 7'h4f;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CH_C     = 7'h43;
    localparam logic [CHAR_W-1:0] CH_D     = 7'h44;
    localparam logic [CHAR_W-1:0] CH_Z     = 7'h5a;
    localparam logic [CHAR_W-1:0] CH_SIX   = 7'h36;
    localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7e;
    localparam logic [CHAR_W-1:0] CH_Q     = 7'h71;
    localparam logic [CHAR_W-1:0] CH_DEL   = 7'h7f;
    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CH_FIVE  = 7'h05;

    // Key index to register index and to the code that a completed key emits.
    localparam logic [CFG_ADDR_W-1:0] KEY_REG_OF [KSM_NUM_KEYS] =
        '{REG_KEY_LEFT, REG_KEY_RIGHT, REG_KEY_UP, REG_KEY_DOWN};
    localparam logic [CHAR_W-1:0] KEY_CODE_OF [KSM_NUM_KEYS] =
        '{CODE_LEFT, CODE_RIGHT, CODE_UP, CODE_DOWN};

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] ch;
    } key_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } key_result_t;

    typedef struct packed {
        logic [CFG_ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]      data;
    } key_write_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_mode_e;

    // Clock, reset and all block inputs start at known values.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [SEQ_W-1:0]      i_cfg_wdata = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata     = '0;   // [6:0] char_in, [7] zero
    logic                  s_tuser     = 1'b0; // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [7:0]            m_tdata;            // [6:0] char_out, [7] zero
    logic                  m_tlast;

    key_sequence_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor. It keeps its own copy of the four key registers and of
    // the per-key match positions, and turns every accepted request into
    // the characters that must come out, in order.
    // ------------------------------------------------------------------
    logic [SEQ_W-1:0] key_regs [KSM_NUM_KEYS] = '{default: '0};
    logic [IDX_W-1:0] key_pos  [KSM_NUM_KEYS] = '{default: '0};
    key_result_t      awaited_chars [$];
    int unsigned      error_count = 0;

    function automatic void clear_prefixes();
        int k;
        for (k = 0; k < KSM_NUM_KEYS; k++) key_pos[k] = '0;
    endfunction

    // Key holding the longest partial match; the lowest key wins a tie.
    function automatic int longest_prefix_key();
        int k;
        int best;
        best = -1;
        for (k = 0; k < KSM_NUM_KEYS; k++) begin
            if (key_pos[k] != '0 && (best < 0 || key_pos[best] < key_pos[k])) best = k;
        end
        return best;
    endfunction

    // Replays the matched part of a key; on a timeout the last replayed
    // character closes the run.
    function automatic void replay_prefix(input int best, input logic ends_run);
        int          cnt;
        int          i;
        key_result_t r;
        if (best < 0) return;
        cnt = int'(key_pos[best]);
        if (cnt > KSM_MAX_KEY_LEN) cnt = KSM_MAX_KEY_LEN;
        for (i = 0; i < cnt; i++) begin
            r.ch   = key_regs[best][i * CHAR_W +: CHAR_W];
            r.last = ends_run && (i == cnt - 1);
            awaited_chars.push_back(r);
        end
    endfunction

    function automatic void decode_request(input key_req_t req);
        int          k;
        int          len;
        logic        stepped;
        key_result_t r;
        stepped = 1'b0;
        if (req.cmd == CMD_TIMEOUT) begin
            // A timeout flushes whatever prefix is pending; the character is ignored.
            replay_prefix(longest_prefix_key(), 1'b1);
            clear_prefixes();
            return;
        end
        for (k = 0; k < KSM_NUM_KEYS; k++) begin
            len = int'(key_regs[k][SEQ_W-1:LEN_LSB]);
            if (len > KSM_MAX_KEY_LEN) len = KSM_MAX_KEY_LEN;
            if (len != 0 && int'(key_pos[k]) < len &&
                key_regs[k][int'(key_pos[k]) * CHAR_W +: CHAR_W] == req.ch) begin
                stepped    = 1'b1;
                key_pos[k] = key_pos[k] + 1'b1;
                if (int'(key_pos[k]) == len) begin
                    r.ch   = KEY_CODE_OF[k];
                    r.last = 1'b1;
                    awaited_chars.push_back(r);
                    clear_prefixes();
                    return;
                end
            end
        end
        // Some key is still matching: hold everything back for now.
        if (stepped) return;
        replay_prefix(longest_prefix_key(), 1'b0);
        r.ch   = req.ch;
        r.last = 1'b1;
        awaited_chars.push_back(r);
        clear_prefixes();
    endfunction

    function automatic void load_key(input logic [CFG_ADDR_W-1:0] addr,
                                     input logic [SEQ_W-1:0] data);
        key_regs[addr] = data;
        key_pos[addr]  = '0;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. It sends register writes first (these are queued only
    // while the block is idle), then requests from the pending queue in
    // bursts of random length separated by random gaps. Each request is
    // handed to the predictor at the edge where it is accepted.
    // ------------------------------------------------------------------
    key_req_t    pending_reqs [$];
    key_write_t  key_writes [$];
    key_req_t    offered_req;
    int unsigned burst_left = 1;
    int unsigned send_gap   = 0;

    always @(posedge i_clk) begin : request_driver
        key_write_t wr;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) decode_request(offered_req);
            if (i_cfg_we) load_key(i_cfg_addr, i_cfg_wdata);
            if (s_tvalid && !s_tready) begin
                // The request stays on the bus until the block takes it.
                i_cfg_we <= 1'b0;
            end else if (key_writes.size() != 0) begin
                wr = key_writes.pop_front();
                i_cfg_we    <= 1'b1;
                i_cfg_addr  <= wr.addr;
                i_cfg_wdata <= wr.data;
                s_tvalid    <= 1'b0;
            end else begin
                i_cfg_we <= 1'b0;
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    offered_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, offered_req.ch};
                    s_tuser  <= offered_req.cmd;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // A third of the bursts run straight into the next one.
                        burst_left = $urandom_range(1, 16);
                        send_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side. The receiver switches between stall patterns at random
    // intervals and, once on request, holds off for a long stretch so
    // that the job queue fills and the block stops taking requests.
    // ------------------------------------------------------------------
    bit          long_hold_wanted = 1'b0;
    bit          long_hold_done   = 1'b0;
    int unsigned hold_left        = 0;
    int unsigned mode_left        = 0;
    int unsigned rx_tick          = 0;
    rx_mode_e    rx_mode          = RX_ALWAYS;

    always @(posedge i_clk) begin : result_receiver
        logic ready;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (long_hold_wanted && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                ready = 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:      ready = 1'b1;
                    RX_COIN:        ready = ($urandom_range(0, 1) == 1);
                    RX_EVERY_THIRD: ready = (rx_tick % 3 == 0);
                    default:        ready = ($urandom_range(0, 4) == 0);
                endcase
            end
            m_tready <= ready;
        end
    end

    // Every accepted result is checked against the oldest awaited one.
    always @(posedge i_clk) begin : result_monitor
        key_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (awaited_chars.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual char %h last %b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = awaited_chars.pop_front();
                if (m_tdata !== {1'b0, want.ch}) begin
                    $display("%0t: char_out mismatch, expected %h, actual %h",
                             $time, {1'b0, want.ch}, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_of_run mismatch, expected %b, actual %b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. The stimulus side keeps its own note of what each key was
    // programmed to, so that it can build well-formed key sequences.
    // ------------------------------------------------------------------
    logic [SEQ_W-1:0]  planned_seq [KSM_NUM_KEYS] = '{default: '0};
    logic [CHAR_W-1:0] noise_chars [4];
    int unsigned       queued_items = 0;

    task automatic queue_char(input logic [CHAR_W-1:0] ch);
        key_req_t req;
        req.cmd = CMD_CHAR;
        req.ch  = ch;
        pending_reqs.push_back(req);
        queued_items++;
    endtask

    // The character field is random on a timeout since the block ignores it.
    task automatic queue_timeout();
        key_req_t req;
        req.cmd = CMD_TIMEOUT;
        req.ch  = CHAR_W'($urandom_range(0, 127));
        pending_reqs.push_back(req);
        queued_items++;
    endtask

    task automatic program_key(input int k, input logic [SEQ_W-1:0] value);
        key_write_t wr;
        wr.addr = KEY_REG_OF[k];
        wr.data = value;
        key_writes.push_back(wr);
        planned_seq[k] = value;
    endtask

    function automatic logic [SEQ_W-1:0] make_key(input logic [3:0] len,
                                                  input logic [CHAR_W-1:0] c0, c1, c2, c3);
        return {len, 28'h0, c3, c2, c1, c0};
    endfunction

    // Waits until every request is in, every result is out and the block
    // has had time to finish requests that produce nothing.
    task automatic settle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || s_tvalid || key_writes.size() != 0 || i_cfg_we ||
               awaited_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed key sequences, whole or cut short by a timeout or
    // a stray character, mixed with noise from a small alphabet (so that
    // partial matches pile up), fully random characters and timeouts.
    task automatic run_random_phase(input int unsigned n_items, input bit fresh_keys,
                                    input bit with_long_hold);
        int unsigned target;
        int          k;
        int          i;
        int          len;
        int          pick;
        int          p;
        logic [63:0] r64;
        logic [SEQ_W-1:0] value;
        if (fresh_keys) begin
            for (i = 0; i < 4; i++) noise_chars[i] = CHAR_W'($urandom_range(0, 127));
            for (k = 0; k < KSM_NUM_KEYS; k++) begin
                // Some keys keep their old setting, and with it their match position.
                if ($urandom_range(0, 4) != 0) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)      len = 0;
                    else if (pick == 1) len = $urandom_range(5, 15);
                    else                len = $urandom_range(1, 4);
                    r64   = {$urandom(), $urandom()};
                    value = r64[SEQ_W-1:0];
                    for (i = 0; i < KSM_MAX_KEY_LEN; i++) begin
                        if (i < len) value[i * CHAR_W +: CHAR_W] = noise_chars[$urandom_range(0, 3)];
                    end
                    value[SEQ_W-1:LEN_LSB] = 4'(len);
                    program_key(k, value);
                end
            end
        end
        target = queued_items + n_items;
        while (queued_items < target) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, KSM_NUM_KEYS - 1);
            len  = int'(planned_seq[k][SEQ_W-1:LEN_LSB]);
            if (len > KSM_MAX_KEY_LEN) len = KSM_MAX_KEY_LEN;
            if (pick < 70 && len != 0) begin
                p = $urandom_range(1, len);
                for (i = 0; i < p; i++) queue_char(planned_seq[k][i * CHAR_W +: CHAR_W]);
                if (p < len) begin
                    case ($urandom_range(0, 2))
                        0:       queue_timeout();
                        1:       queue_char(noise_chars[$urandom_range(0, 3)]);
                        default: ;
                    endcase
                end
            end else if (pick < 85) begin
                queue_char(noise_chars[$urandom_range(0, 3)]);
            end else if (pick < 94) begin
                queue_char(CHAR_W'($urandom_range(0, 127)));
            end else begin
                queue_timeout();
            end
        end
        if (with_long_hold) long_hold_wanted = 1'b1;
        settle();
    endtask

    initial begin : stimulus
        int i;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Out of reset every key is disabled: characters pass straight
        // through and a timeout has nothing to flush.
        queue_char(CH_NUL);
        queue_timeout();
        settle();

        // Escape-style keys that share a common start.
        program_key(0, make_key(4'd3, CH_ESC, CH_LBRKT, CH_D, CH_NUL));
        program_key(1, make_key(4'd3, CH_ESC, CH_LBRKT, CH_C, CH_NUL));
        program_key(2, make_key(4'd3, CH_ESC, CH_O, CH_A, CH_NUL));
        program_key(3, make_key(4'd4, CH_ESC, CH_LBRKT, CH_SIX, CH_TILDE));
        // A complete left key.
        queue_char(CH_ESC);
        queue_char(CH_LBRKT);
        queue_char(CH_D);
        // Keys that do not advance keep their position, so after this the
        // four-way tie at length two goes to the left key and its prefix
        // is replayed ahead of the breaking character.
        queue_char(CH_ESC);
        queue_char(CH_O);
        queue_char(CH_LBRKT);
        queue_char(CH_Z);
        // Timeout with a pending prefix, then a timeout with none.
        queue_char(CH_ESC);
        queue_timeout();
        queue_timeout();
        // The longest key, and one that completes late among the others.
        queue_char(CH_ESC);
        queue_char(CH_LBRKT);
        queue_char(CH_SIX);
        queue_char(CH_TILDE);
        settle();

        // Extremes: every register bit set (length above the maximum),
        // a full-length key of zero characters, a one-character key and a
        // disabled key whose character bits are all set.
        program_key(0, {SEQ_W{1'b1}});
        program_key(1, {4'd8, 56'h0});
        program_key(2, make_key(4'd1, CH_Q, CH_NUL, CH_NUL, CH_NUL));
        program_key(3, {4'd0, {56{1'b1}}});
        // Seven matched characters replayed in front of the breaking one.
        for (i = 0; i < 7; i++) queue_char(CH_NUL);
        queue_char(CH_FIVE);
        queue_char(CH_Q);
        // Leave a partial left match pending across a rewrite of that key.
        queue_char(CH_DEL);
        queue_char(CH_DEL);
        settle();
        program_key(0, {SEQ_W{1'b1}});
        queue_timeout();
        settle();

        // Random traffic: first on the extreme keys, then on fresh key sets.
        noise_chars[0] = CH_DEL;
        noise_chars[1] = CH_NUL;
        noise_chars[2] = CH_Q;
        noise_chars[3] = CH_FIVE;
        run_random_phase(50, 1'b0, 1'b0);
        run_random_phase(55, 1'b1, 1'b0);
        run_random_phase(55, 1'b1, 1'b0);
        run_random_phase(55, 1'b1, 1'b1);
        run_random_phase(55, 1'b1, 1'b0);
        run_random_phase(55, 1'b1, 1'b0);

        if (error_count == 0 && awaited_chars.size() == 0) begin
            $display("tb_key_sequence_matcher passed");
        end else begin
            $display("tb_key_sequence_matcher failed");
        end
        $finish;
    end

    // Ends a hung run.
    initial begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < RUN_LIMIT; cycles++) @(posedge i_clk);
        $display("tb_key_sequence_matcher failed");
        $finish;
    end

endmodule

[key_sequence_matcher.f]
hw/rtl/ksm_pkg.sv
hw/rtl/ksm_front.sv
hw/rtl/ksm_queue.sv
hw/rtl/ksm_back.sv
hw/rtl/key_sequence_matcher.sv
tb/tb_key_sequence_matcher.sv
